### rtl/core/mouse_motion_accumulator_core_macros.svh
// Assertion macros of the mouse motion accumulator RTL, used by the controller.
`ifndef MOUSE_MOTION_ACCUMULATOR_CORE_MACROS_SVH
`define MOUSE_MOTION_ACCUMULATOR_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define MMA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/core/mma_pkg.sv
// Types, constants and helper functions of the mouse motion accumulator.
`default_nettype none
package mma_pkg;

  localparam int MICE      = 16;
  localparam int IDX_W     = (MICE > 1) ? $clog2(MICE) : 1;
  localparam int KIND_W    = 3;
  localparam int MOUSE_W   = 4;
  localparam int DELTA_W   = 12;
  localparam int BTN_W     = 7;
  localparam int ACC_W     = 13;
  localparam int PKT_W     = 8;
  localparam int CNT_W     = 8;
  localparam int ACC_LIMIT = 2048;
  localparam int PKT_LIMIT = 127;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [PKT_W-1:0] HDR_MARK  = 8'h80;
  localparam logic [CNT_W-1:0] OPEN_MAX  = 8'hFF;
  localparam logic [BTN_W-1:0] BTN_RESET = 7'd7;

  typedef enum logic [KIND_W-1:0] {
    KIND_MOVE_BTN = 3'd0,
    KIND_MOVE     = 3'd1,
    KIND_BTN      = 3'd2,
    KIND_READ     = 3'd3,
    KIND_OPEN     = 3'd4,
    KIND_RELEASE  = 3'd5
  } kind_e;

  typedef enum logic [0:0] {
    REG_INITIAL_BUTTONS = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic latch;
    logic exec;
  } dp_cmd_t;

  function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [ACC_W:0] v);
    if (v > ACC_LIMIT) return ACC_W'(ACC_LIMIT);
    if (v < -ACC_LIMIT) return ACC_W'(-ACC_LIMIT);
    return v[ACC_W-1:0];
  endfunction

  function automatic logic signed [PKT_W-1:0] clamp_pkt(input logic signed [ACC_W-1:0] v);
    if (v > PKT_LIMIT) return PKT_W'(PKT_LIMIT);
    if (v < -PKT_LIMIT) return PKT_W'(-PKT_LIMIT);
    return v[PKT_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/mouse_motion_accumulator_core.sv
// Top level of the mouse motion accumulator: stream ports, register port, core wiring.
`default_nettype none
// Motion accumulator for MICE mice (16). Each input beat names one mouse and one event
// kind (tuser): motion and button events fold saturating deltas into that mouse's
// accumulators, a read returns a clamped three-byte packet, open and release keep a per-mouse
// open count. Every input beat yields exactly one output beat. The IDLE state captures the
// beat, then EXEC read-modify-writes the selected mouse's register set and loads the
// output register; a stalled output holds EXEC. A new beat is taken while the previous
// result still waits downstream. initial_buttons sits at byte address 0 of the register
// port; the user must write it only while the block is idle; the block does not enforce it.
module mouse_motion_accumulator_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // mouse[3:0], delta_x[15:4], delta_y[27:16], new_buttons[34:28], clear_mask[41:35],
  // flip_mask[48:42], zero pad
  input  wire  [mma_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind[2:0]
  input  wire  [mma_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // header_byte[7:0], packet_x[15:8], packet_y[23:16], buttons_now[30:24], data_ready[31],
  // changed[32], zero pad
  output logic [mma_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status[0]
  output logic                             m_axis_tuser,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [mma_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire  [mma_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mma_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import mma_pkg::*;

  logic [BTN_W-1:0]          init_btn_q;
  reg_idx_e                  reg_idx;
  dp_cmd_t                   cmd;
  logic                      status;
  logic [PKT_W-1:0]          hdr;
  logic signed [PKT_W-1:0]   px, py;
  logic [BTN_W-1:0]          btn_now;
  logic                      rdy, chg;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_btn_q <= BTN_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_INITIAL_BUTTONS) begin
      init_btn_q <= pwdata[BTN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_INITIAL_BUTTONS: prdata = APB_DATA_W'(init_btn_q);
      default:             prdata = '0;
    endcase
  end

  mma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  mma_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .kind_i            (s_axis_tuser),
    .mouse_i           (s_axis_tdata[3:0]),
    .delta_x_i         (s_axis_tdata[15:4]),
    .delta_y_i         (s_axis_tdata[27:16]),
    .new_buttons_i     (s_axis_tdata[34:28]),
    .clear_mask_i      (s_axis_tdata[41:35]),
    .flip_mask_i       (s_axis_tdata[48:42]),
    .initial_buttons_i (init_btn_q),
    .status_o          (status),
    .header_byte_o     (hdr),
    .packet_x_o        (px),
    .packet_y_o        (py),
    .buttons_now_o     (btn_now),
    .data_ready_o      (rdy),
    .changed_o         (chg)
  );

  assign m_axis_tdata = {7'd0, chg, rdy, btn_now, py, px, hdr};
  assign m_axis_tuser = status;

endmodule
`default_nettype wire

### rtl/core/mma_ctrl.sv
// Controller: beat capture, register-set update sequencing and output valid.
`default_nettype none
`include "mouse_motion_accumulator_core_macros.svh"
module mma_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output mma_pkg::dp_cmd_t cmd_o
);
  import mma_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  dp_cmd_t cmd;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd         = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.latch = 1'b1;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `MMA_ASSERT(a_accept_to_exec, (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC), "accepted beat not executed")
  `MMA_ASSERT(a_exec_sets_valid, cmd.exec |=> out_valid_q, "update without output beat")
  `MMA_NEVER(a_exec_over_pending, cmd.exec && out_valid_q && !out_ready_i, "output beat overwritten")
  `MMA_NEVER(a_latch_during_exec, cmd.latch && cmd.exec, "capture and update together")

endmodule
`default_nettype wire

### rtl/core/mma_datapath.sv
// Datapath: captured beat, per-mouse register sets, update logic and output register.
`default_nettype none
module mma_datapath (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  mma_pkg::dp_cmd_t                    cmd_i,
  input  wire  [mma_pkg::KIND_W-1:0]          kind_i,
  input  wire  [mma_pkg::MOUSE_W-1:0]         mouse_i,
  input  wire  signed [mma_pkg::DELTA_W-1:0]  delta_x_i,
  input  wire  signed [mma_pkg::DELTA_W-1:0]  delta_y_i,
  input  wire  [mma_pkg::BTN_W-1:0]           new_buttons_i,
  input  wire  [mma_pkg::BTN_W-1:0]           clear_mask_i,
  input  wire  [mma_pkg::BTN_W-1:0]           flip_mask_i,
  input  wire  [mma_pkg::BTN_W-1:0]           initial_buttons_i,
  output logic                                status_o,
  output logic [mma_pkg::PKT_W-1:0]           header_byte_o,
  output logic signed [mma_pkg::PKT_W-1:0]    packet_x_o,
  output logic signed [mma_pkg::PKT_W-1:0]    packet_y_o,
  output logic [mma_pkg::BTN_W-1:0]           buttons_now_o,
  output logic                                data_ready_o,
  output logic                                changed_o
);
  import mma_pkg::*;

  kind_e                      kind_q;
  logic [MOUSE_W-1:0]         mouse_q;
  logic signed [DELTA_W-1:0]  dx_q, dy_q;
  logic [BTN_W-1:0]           nb_q, clr_q, flp_q;

  logic signed [ACC_W-1:0]    x_q [MICE];
  logic signed [ACC_W-1:0]    y_q [MICE];
  logic [BTN_W-1:0]           btn_q [MICE];
  logic                       rdy_q [MICE];
  logic [CNT_W-1:0]           cnt_q [MICE];

  logic [IDX_W-1:0]           idx;
  logic                       in_range;
  logic signed [ACC_W-1:0]    cur_x, cur_y, nx, ny;
  logic [BTN_W-1:0]           cur_btn, nbtn, cand_btn;
  logic                       cur_rdy, nrdy;
  logic [CNT_W-1:0]           cur_cnt, ncnt;
  logic signed [DELTA_W-1:0]  mdx, mdy;
  logic signed [PKT_W-1:0]    px, py;
  logic                       wr, chg, st;
  logic [PKT_W-1:0]           hdr;

  logic                       status_q, rdy_out_q, chg_q;
  logic [PKT_W-1:0]           hdr_q;
  logic signed [PKT_W-1:0]    px_q, py_q;
  logic [BTN_W-1:0]           btn_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= kind_e'(kind_i);
      mouse_q <= mouse_i;
      dx_q    <= delta_x_i;
      dy_q    <= delta_y_i;
      nb_q    <= new_buttons_i;
      clr_q   <= clear_mask_i;
      flp_q   <= flip_mask_i;
    end
  end

  assign idx      = IDX_W'(mouse_q);
  assign in_range = int'(mouse_q) < MICE;
  assign cur_x    = x_q[idx];
  assign cur_y    = y_q[idx];
  assign cur_btn  = btn_q[idx];
  assign cur_rdy  = rdy_q[idx];
  assign cur_cnt  = cnt_q[idx];

  always_comb begin
    nx       = cur_x;
    ny       = cur_y;
    nbtn     = cur_btn;
    nrdy     = cur_rdy;
    ncnt     = cur_cnt;
    mdx      = dx_q;
    mdy      = dy_q;
    cand_btn = cur_btn;
    px       = '0;
    py       = '0;
    hdr      = '0;
    chg      = 1'b0;
    st       = 1'b0;
    unique case (kind_q)
      KIND_MOVE_BTN, KIND_MOVE, KIND_BTN: begin
        if (kind_q == KIND_MOVE_BTN) begin
          cand_btn = nb_q;
        end else if (kind_q == KIND_BTN) begin
          mdx      = '0;
          mdy      = '0;
          cand_btn = (cur_btn & ~clr_q) ^ flp_q;
        end
        if (mdx != '0 || mdy != '0 || cand_btn != cur_btn) begin
          chg  = 1'b1;
          nbtn = cand_btn;
          nx   = clamp_acc((ACC_W+1)'(cur_x) + (ACC_W+1)'(mdx));
          ny   = clamp_acc((ACC_W+1)'(cur_y) + (ACC_W+1)'(mdy));
          nrdy = 1'b1;
        end
      end
      KIND_READ: begin
        if (!cur_rdy) begin
          st = 1'b1;
        end else begin
          px   = clamp_pkt(cur_x);
          py   = clamp_pkt(cur_y);
          nx   = cur_x - ACC_W'(px);
          ny   = cur_y - ACC_W'(py);
          nrdy = (nx != '0) || (ny != '0);
          hdr  = {1'b0, cur_btn} | HDR_MARK;
        end
      end
      KIND_OPEN: begin
        if (cur_cnt != OPEN_MAX) begin
          if (cur_cnt == '0) begin
            nrdy = 1'b0;
            nx   = '0;
            ny   = '0;
            nbtn = initial_buttons_i;
          end
          ncnt = cur_cnt + CNT_W'(1);
        end
      end
      KIND_RELEASE: begin
        if (cur_cnt != '0) begin
          ncnt = cur_cnt - CNT_W'(1);
          if (ncnt == '0) begin
            nrdy = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign wr = cmd_i.exec && in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MICE; i++) begin
        x_q[i]   <= '0;
        y_q[i]   <= '0;
        btn_q[i] <= '0;
        rdy_q[i] <= 1'b0;
        cnt_q[i] <= '0;
      end
    end else if (wr) begin
      x_q[idx]   <= nx;
      y_q[idx]   <= ny;
      btn_q[idx] <= nbtn;
      rdy_q[idx] <= nrdy;
      cnt_q[idx] <= ncnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (in_range) begin
        status_q  <= st;
        hdr_q     <= hdr;
        px_q      <= px;
        py_q      <= py;
        btn_out_q <= nbtn;
        rdy_out_q <= nrdy;
        chg_q     <= chg;
      end else begin
        status_q  <= (kind_q == KIND_READ);
        hdr_q     <= '0;
        px_q      <= '0;
        py_q      <= '0;
        btn_out_q <= '0;
        rdy_out_q <= 1'b0;
        chg_q     <= 1'b0;
      end
    end
  end

  assign status_o      = status_q;
  assign header_byte_o = hdr_q;
  assign packet_x_o    = px_q;
  assign packet_y_o    = py_q;
  assign buttons_now_o = btn_out_q;
  assign data_ready_o  = rdy_out_q;
  assign changed_o     = chg_q;

endmodule
`default_nettype wire

### tb/tb_mouse_motion_accumulator_core.sv
// Self-checking testbench for the mouse motion accumulator core.
module tb_mouse_motion_accumulator_core;
  import mma_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASE_ITEMS = 265;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [MOUSE_W-1:0]        mouse;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [BTN_W-1:0]          nb;
    logic [BTN_W-1:0]          clr;
    logic [BTN_W-1:0]          flp;
  } mouse_event_t;

  typedef struct packed {
    logic             status;
    logic [PKT_W-1:0] hdr;
    logic [PKT_W-1:0] px;
    logic [PKT_W-1:0] py;
    logic [BTN_W-1:0] buttons;
    logic             ready;
    logic             changed;
  } mouse_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [KIND_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic signed [ACC_W-1:0] acc_x [MICE];
  logic signed [ACC_W-1:0] acc_y [MICE];
  logic [BTN_W-1:0]        btn_state [MICE];
  logic                    ready_state [MICE];
  logic [CNT_W-1:0]        open_cnt [MICE];
  logic [BTN_W-1:0]        init_btn;

  mouse_report_t expected_reports [$];

  int mismatch_count = 0;
  int beats_sent = 0;
  int reads_with_data = 0;
  int empty_reads = 0;
  int state_changes = 0;
  int settings_written = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  mouse_motion_accumulator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic int saturate(input int v, input int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic mouse_report_t apply_event(input mouse_event_t ev);
    mouse_report_t    r;
    int               m;
    int               sx;
    int               sy;
    int               px;
    int               py;
    logic [BTN_W-1:0] b;
    r = '0;
    m = ev.mouse;
    sx = ev.dx;
    sy = ev.dy;
    case (ev.kind)
      KIND_MOVE_BTN, KIND_MOVE, KIND_BTN: begin
        if (ev.kind == KIND_MOVE_BTN) begin
          b = ev.nb;
        end else if (ev.kind == KIND_MOVE) begin
          b = btn_state[m];
        end else begin
          sx = 0;
          sy = 0;
          b = (btn_state[m] & ~ev.clr) ^ ev.flp;
        end
        if (sx != 0 || sy != 0 || b != btn_state[m]) begin
          r.changed = 1'b1;
          btn_state[m] = b;
          acc_x[m] = ACC_W'(saturate(acc_x[m] + sx, ACC_LIMIT));
          acc_y[m] = ACC_W'(saturate(acc_y[m] + sy, ACC_LIMIT));
          ready_state[m] = 1'b1;
        end
      end
      KIND_READ: begin
        if (!ready_state[m]) begin
          r.status = 1'b1;
        end else begin
          px = saturate(acc_x[m], PKT_LIMIT);
          py = saturate(acc_y[m], PKT_LIMIT);
          acc_x[m] = ACC_W'(acc_x[m] - px);
          acc_y[m] = ACC_W'(acc_y[m] - py);
          ready_state[m] = (acc_x[m] != 0) || (acc_y[m] != 0);
          r.hdr = HDR_MARK | PKT_W'(btn_state[m]);
          r.px = PKT_W'(px);
          r.py = PKT_W'(py);
        end
      end
      KIND_OPEN: begin
        if (open_cnt[m] != OPEN_MAX) begin
          if (open_cnt[m] == '0) begin
            ready_state[m] = 1'b0;
            acc_x[m] = '0;
            acc_y[m] = '0;
            btn_state[m] = init_btn;
          end
          open_cnt[m] = open_cnt[m] + 1'b1;
        end
      end
      KIND_RELEASE: begin
        if (open_cnt[m] != '0) begin
          open_cnt[m] = open_cnt[m] - 1'b1;
          if (open_cnt[m] == '0) ready_state[m] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.buttons = btn_state[m];
    r.ready = ready_state[m];
    return r;
  endfunction

  function automatic mouse_event_t make_event(input logic [KIND_W-1:0] kind,
                                              input int mouse, input int dx, input int dy,
                                              input int nb, input int clr, input int flp);
    mouse_event_t ev;
    ev.kind = kind;
    ev.mouse = MOUSE_W'(mouse);
    ev.dx = DELTA_W'(dx);
    ev.dy = DELTA_W'(dy);
    ev.nb = BTN_W'(nb);
    ev.clr = BTN_W'(clr);
    ev.flp = BTN_W'(flp);
    return ev;
  endfunction

  function automatic int random_delta();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return 0;
    if (pick < 6) return int'($urandom_range(0, 16)) - 8;
    if (pick < 8) return int'($urandom_range(0, 4095)) - 2048;
    if (pick == 8) return ($urandom_range(0, 1) != 0) ? 2047 : -2048;
    return int'($urandom_range(0, 600)) - 300;
  endfunction

  function automatic mouse_event_t random_event();
    mouse_event_t ev;
    int           pick;
    int           m;
    m = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, MICE - 1);
    pick = $urandom_range(0, 99);
    ev = make_event(KIND_MOVE, m, random_delta(), random_delta(), $urandom_range(0, 127),
                    $urandom_range(0, 127), $urandom_range(0, 127));
    if (pick < 20) begin
      ev.kind = KIND_MOVE_BTN;
      if ($urandom_range(0, 2) == 0) ev.nb = btn_state[m];
    end else if (pick < 38) begin
      ev.kind = KIND_MOVE;
    end else if (pick < 52) begin
      ev.kind = KIND_BTN;
      if ($urandom_range(0, 4) == 0) begin
        ev.clr = '0;
        ev.flp = '0;
      end
    end else if (pick < 80) begin
      ev.kind = KIND_READ;
    end else if (pick < 88) begin
      ev.kind = KIND_OPEN;
    end else if (pick < 96) begin
      ev.kind = KIND_RELEASE;
    end else begin
      ev.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_A : KIND_SPARE_B;
    end
    return ev;
  endfunction

  task automatic send_event(input mouse_event_t ev);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tdata <= {7'b0, ev.flp, ev.clr, ev.nb, ev.dy, ev.dx, ev.mouse};
    s_axis_tuser <= ev.kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_reports.push_back(apply_event(ev));
    beats_sent++;
  endtask

  task automatic drain_reports();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_initial_buttons(input logic [BTN_W-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * REG_INITIAL_BUTTONS);
    pwdata <= {(APB_DATA_W - BTN_W)'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    init_btn = value;
    settings_written++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_event(make_event(KIND_READ, 0, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_MOVE_BTN, 3, 2047, -2048, 127, 0, 0));
    send_event(make_event(KIND_MOVE_BTN, 3, 2047, -2048, 127, 0, 0));
    send_event(make_event(KIND_READ, 3, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_MOVE, 3, 0, 0, 0, 127, 127));
    send_event(make_event(KIND_BTN, 3, 5, 5, 0, 0, 0));
    send_event(make_event(KIND_BTN, 3, 0, 0, 0, 127, 0));
    send_event(make_event(KIND_BTN, 3, 0, 0, 0, 0, 127));
    send_event(make_event(KIND_BTN, 3, -2048, 2047, 0, 85, 42));
    send_event(make_event(KIND_MOVE_BTN, 3, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_MOVE, 3, -1, 1, 127, 0, 0));
    send_event(make_event(KIND_SPARE_A, 3, 100, 100, 127, 127, 127));
    send_event(make_event(KIND_SPARE_B, 15, -100, -100, 127, 127, 127));
    send_event(make_event(KIND_OPEN, 15, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_MOVE_BTN, 15, 5, -5, 1, 0, 0));
    send_event(make_event(KIND_OPEN, 15, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_RELEASE, 15, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_RELEASE, 15, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_RELEASE, 15, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_READ, 15, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_MOVE, 15, 0, 1, 0, 0, 0));
    send_event(make_event(KIND_READ, 15, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_READ, 3, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_MOVE_BTN, 0, -2048, 2047, 0, 0, 0));
    send_event(make_event(KIND_READ, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_open_count_saturation();
    repeat (256) send_event(make_event(KIND_OPEN, 9, 0, 0, 0, 0, 0));
    send_event(make_event(KIND_MOVE_BTN, 9, 1, 0, 0, 0, 0));
    repeat (256) send_event(make_event(KIND_RELEASE, 9, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(input logic [BTN_W-1:0] btn_init, input int count);
    drain_reports();
    write_initial_buttons(btn_init);
    repeat (count) send_event(random_event());
  endtask

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 80);
    end
    stall_left--;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) != 0);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    mouse_report_t got;
    mouse_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.hdr = m_axis_tdata[7:0];
      got.px = m_axis_tdata[15:8];
      got.py = m_axis_tdata[23:16];
      got.buttons = m_axis_tdata[30:24];
      got.ready = m_axis_tdata[31];
      got.changed = m_axis_tdata[32];
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected report beat at cycle %0d", cycle_count);
      end else begin
        want = expected_reports.pop_front();
        if (want.status) empty_reads++;
        else if (want.hdr != '0) reads_with_data++;
        if (want.changed) state_changes++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("report mismatch at cycle %0d", cycle_count);
            $display("  want st=%0d hdr=%h x=%0d y=%0d btn=%h rdy=%0d chg=%0d",
                     want.status, want.hdr, $signed(want.px), $signed(want.py),
                     want.buttons, want.ready, want.changed);
            $display("  got  st=%0d hdr=%h x=%0d y=%0d btn=%h rdy=%0d chg=%0d",
                     got.status, got.hdr, $signed(got.px), $signed(got.py),
                     got.buttons, got.ready, got.changed);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               expected_reports.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MICE; i++) begin
      acc_x[i] = '0;
      acc_y[i] = '0;
      btn_state[i] = '0;
      ready_state[i] = 1'b0;
      open_cnt[i] = '0;
    end
    init_btn = BTN_RESET;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_open_count_saturation();
    test_random_traffic(7'd0, RANDOM_PHASE_ITEMS);
    test_random_traffic(7'd127, RANDOM_PHASE_ITEMS);
    test_random_traffic(BTN_W'($urandom), RANDOM_PHASE_ITEMS);
    test_random_traffic(BTN_W'($urandom), RANDOM_PHASE_ITEMS);
    test_random_traffic(BTN_RESET, RANDOM_PHASE_ITEMS);

    drain_reports();
    repeat (8) @(posedge clk_i);
    $display("sent %0d beats over %0d initial-button settings: %0d state changes,",
             beats_sent, settings_written, state_changes);
    $display("%0d reads with a packet, %0d reads without data, %0d mismatches",
             reads_with_data, empty_reads, mismatch_count);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
